FILE: hdl/kdc_pkg.sv
// Kirsch directional code package: widths, candidate type and compare helpers.
// Used by kirsch_directional_code; depends on nothing.
package kdc_pkg;

    localparam int PIX_W   = 8;
    localparam int SUM_W   = PIX_W + 2;
    localparam int DIR_W   = 3;
    localparam int CODE_W  = 6;
    localparam int NUM_DIR = 8;

    typedef logic [PIX_W-1:0]  t_pix;
    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [DIR_W-1:0]  t_dir;
    typedef logic [CODE_W-1:0] t_code;

    typedef struct packed {
        t_sum sum;
        t_dir dir;
    } t_cand;

    localparam t_code CODE_BORDER = '0;

    // a carries the lower direction; b wins only when strictly better
    function automatic t_cand pick_max(input t_cand a, input t_cand b);
        pick_max = (b.sum > a.sum) ? b : a;
    endfunction

    function automatic t_cand pick_min(input t_cand a, input t_cand b);
        pick_min = (b.sum < a.sum) ? b : a;
    endfunction

    function automatic t_sum sum3(input t_pix a, input t_pix b, input t_pix c);
        sum3 = {2'b00, a} + {2'b00, b} + {2'b00, c};
    endfunction

endpackage

FILE: hdl/kirsch_directional_code.sv
// An accepted word moves through stages 1 to 4 in order to its code word on the output register.
// Throughput: one word per cycle unless i_ready stalls; stage 1 forms the eight three-pixel sums,
// stages 2 to 4 each take one level of the max/min compare tree, and stage 4 also registers the code.
// Each response equals 8 * (three-pixel sum) - 3 * (ring sum), so ranking the sums ranks
// the responses. Synchronous active-low reset clears all stage valid bits; data is not reset.
// Depends on kdc_pkg.
module kirsch_directional_code
    import kdc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  t_pix          i_pix_nw,
    input  t_pix          i_pix_n,
    input  t_pix          i_pix_ne,
    input  t_pix          i_pix_w,
    input  t_pix          i_pix_c,
    input  t_pix          i_pix_e,
    input  t_pix          i_pix_sw,
    input  t_pix          i_pix_s,
    input  t_pix          i_pix_se,
    input  logic          i_at_border,
    output logic          o_valid,
    input  logic          i_ready,
    output t_code         o_pattern_code
);

    logic  r_v1, r_v2, r_v3, r_v4;
    logic  r_bord1, r_bord2, r_bord3, r_bord4;
    t_sum  r_sum1 [NUM_DIR];
    t_cand r_mx2 [4];
    t_cand r_mn2 [4];
    t_cand r_mx3 [2];
    t_cand r_mn3 [2];
    t_code r_code4;

    logic  w_ld1, w_ld2, w_ld3, w_ld4;
    t_sum  n_sum1 [NUM_DIR];
    t_cand n_mx2 [4];
    t_cand n_mn2 [4];
    t_cand n_mx3 [2];
    t_cand n_mn3 [2];
    t_code n_code4;
    t_cand w_mx, w_mn;

    assign w_ld4   = !r_v4 || i_ready;
    assign w_ld3   = !r_v3 || w_ld4;
    assign w_ld2   = !r_v2 || w_ld3;
    assign w_ld1   = !r_v1 || w_ld2;
    assign o_ready = w_ld1;

    always_comb begin
        n_sum1[0] = sum3(i_pix_ne, i_pix_e,  i_pix_se);
        n_sum1[1] = sum3(i_pix_n,  i_pix_ne, i_pix_e);
        n_sum1[2] = sum3(i_pix_nw, i_pix_n,  i_pix_ne);
        n_sum1[3] = sum3(i_pix_nw, i_pix_n,  i_pix_w);
        n_sum1[4] = sum3(i_pix_nw, i_pix_w,  i_pix_sw);
        n_sum1[5] = sum3(i_pix_w,  i_pix_sw, i_pix_s);
        n_sum1[6] = sum3(i_pix_sw, i_pix_s,  i_pix_se);
        n_sum1[7] = sum3(i_pix_e,  i_pix_s,  i_pix_se);
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_mx2[k] = pick_max('{sum: r_sum1[2*k],   dir: t_dir'(2*k)},
                                '{sum: r_sum1[2*k+1], dir: t_dir'(2*k+1)});
            n_mn2[k] = pick_min('{sum: r_sum1[2*k],   dir: t_dir'(2*k)},
                                '{sum: r_sum1[2*k+1], dir: t_dir'(2*k+1)});
        end
        for (int k = 0; k < 2; k++) begin
            n_mx3[k] = pick_max(r_mx2[2*k], r_mx2[2*k+1]);
            n_mn3[k] = pick_min(r_mn2[2*k], r_mn2[2*k+1]);
        end
        w_mx = pick_max(r_mx3[0], r_mx3[1]);
        w_mn = pick_min(r_mn3[0], r_mn3[1]);
        n_code4 = r_bord3 ? CODE_BORDER : {w_mx.dir, w_mn.dir};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_ld1) r_v1 <= i_valid;
            if (w_ld2) r_v2 <= r_v1;
            if (w_ld3) r_v3 <= r_v2;
            if (w_ld4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld1) begin
            r_sum1  <= n_sum1;
            r_bord1 <= i_at_border;
        end
        if (w_ld2) begin
            r_mx2   <= n_mx2;
            r_mn2   <= n_mn2;
            r_bord2 <= r_bord1;
        end
        if (w_ld3) begin
            r_mx3   <= n_mx3;
            r_mn3   <= n_mn3;
            r_bord3 <= r_bord2;
        end
        if (w_ld4) begin
            r_code4 <= n_code4;
            r_bord4 <= r_bord3;
        end
    end

    assign o_valid        = r_v4;
    assign o_pattern_code = r_code4;

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_v1)
        else $error("accepted word did not enter stage 1");

    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_bord4) |-> (o_pattern_code == CODE_BORDER))
        else $error("border word gave nonzero code");

    a_max_ge_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (w_mx.sum >= w_mn.sum))
        else $error("max candidate below min candidate");

    a_stage3_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && w_ld4) |=> o_valid)
        else $error("stage 3 word lost on its way to the output");

endmodule
